// File: rtl/thp_pkg.sv
// Shared constants, register indexes and pipeline depths for the sensor compensation block.
`default_nettype none

package thp_pkg;

  // Configuration register indexes.
  localparam int CfgIndexW = 3;
  typedef enum logic [CfgIndexW-1:0] {
    REG_TEMP_CAL  = 3'd0,
    REG_PRESS_LOW = 3'd1,
    REG_PRESS_HIGH = 3'd2,
    REG_PRESS_NINE = 3'd3,
    REG_HUM_CAL   = 3'd4,
    REG_HAS_HUM   = 3'd5
  } cfg_index_t;

  // Divider geometry: one quotient bit per stage.
  localparam int DivW = 64;

  // Stage at which the output registers are loaded, and the accept-to-strobe latency.
  localparam int OutStage = 85;
  localparam int Latency  = OutStage + 1;

  // Delay line lengths between producing and consuming stages.
  localparam int HadcDly = 4;
  localparam int PadcDly = 9;
  localparam int PwDly   = 2;
  localparam int TmcDly  = 78;
  localparam int HumDly  = 69;
  localparam int ZeroDly = 71;
  localparam int NegDly  = 64;
  localparam int PqDly   = 4;
  localparam int MfDly   = 2;

  // Upper bound of the humidity result in milli-percent.
  localparam logic [16:0] HumMaxMrh = 17'd100000;

endpackage

`default_nettype wire

// File: rtl/thp_mul64.sv
// Two-stage multiplier that returns the low 64 bits of a 64 by 64 product.
`default_nettype none

module thp_mul64 (
  input  wire logic        clk,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);
  import thp_pkg::*;

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  // Only the cross terms that land below bit 64 are kept.
  always_ff @(posedge clk) begin
    ll <= a[31:0] * b[31:0];
    lh <= a[31:0] * b[63:32];
    hl <= a[63:32] * b[31:0];
  end

  always_ff @(posedge clk) begin
    p <= ll + {lh + hl, 32'h0};
  end

endmodule

`default_nettype wire

// File: rtl/thp_div.sv
// Pipelined restoring divider for unsigned 64-bit magnitudes, one quotient bit per stage.
`default_nettype none

module thp_div (
  input  wire logic [thp_pkg::DivW-1:0] dividend,
  input  wire logic [thp_pkg::DivW-1:0] divisor,
  input  wire logic                     clk,
  output logic      [thp_pkg::DivW-1:0] quotient
);
  import thp_pkg::*;

  logic [DivW-1:0] rem_q [DivW];
  logic [DivW-1:0] num_q [DivW];
  logic [DivW-1:0] quo_q [DivW];
  logic [DivW-1:0] den_q [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_step
    logic [DivW-1:0] rem_in;
    logic [DivW-1:0] num_in;
    logic [DivW-1:0] quo_in;
    logic [DivW-1:0] den_in;
    logic [DivW:0]   trial;
    logic            fits;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend;
      assign quo_in = '0;
      assign den_in = divisor;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, num_in[DivW-1]};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (fits) begin
        rem_q[k] <= trial[DivW-1:0] - den_in;
      end else begin
        rem_q[k] <= trial[DivW-1:0];
      end
      num_q[k] <= {num_in[DivW-2:0], 1'b0};
      quo_q[k] <= {quo_in[DivW-2:0], fits};
      den_q[k] <= den_in;
    end
  end

  assign quotient = quo_q[DivW-1];

endmodule

`default_nettype wire

// File: rtl/thp_sensor_compensation.sv
// Top level of the temperature, pressure and humidity compensation pipeline.
`default_nettype none

// A transaction is accepted at every rising edge where start is high and busy is low. Busy
// is low whenever reset is released, so a new reading set can be taken on every cycle. Each
// result appears on the result ports for exactly one cycle, marked by done, in acceptance
// order; the receiver cannot stall, so the pipeline never holds. The latency is set mostly by
// the 64-stage restoring divider in the pressure path, one quotient bit per stage; temperature
// and humidity are delayed to line up with it. Calibration registers are written through
// cfg_write, cfg_index and cfg_data and must only change while no transaction is in flight.
// A pressure divisor of zero gives pressure_pa of zero, and has_humidity low forces
// humidity_mrh to zero.
module thp_sensor_compensation (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [19:0]                   temp_raw,
  input  wire logic [19:0]                   press_raw,
  input  wire logic [15:0]                   hum_raw,
  input  wire logic                          cfg_write,
  input  wire logic [thp_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data,
  output logic                               done,
  output logic signed [31:0]                 temperature_mc,
  output logic [23:0]                        pressure_pa,
  output logic [16:0]                        humidity_mrh
);
  import thp_pkg::*;

  // Calibration registers.
  logic [47:0] temp_cal;
  logic [63:0] press_cal_low;
  logic [63:0] press_cal_high;
  logic [15:0] press_cal_nine;
  logic [63:0] hum_cal;
  logic        has_humidity;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal       <= '0;
      press_cal_low  <= '0;
      press_cal_high <= '0;
      press_cal_nine <= '0;
      hum_cal        <= '0;
      has_humidity   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        REG_TEMP_CAL:   temp_cal       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_cal_low  <= cfg_data;
        REG_PRESS_HIGH: press_cal_high <= cfg_data;
        REG_PRESS_NINE: press_cal_nine <= cfg_data[15:0];
        REG_HUM_CAL:    hum_cal        <= cfg_data;
        REG_HAS_HUM:    has_humidity   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Coefficients, extended to the working width of their formula.
  logic signed [31:0] t1_w, t2_w, t3_w;
  logic signed [31:0] h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;
  logic signed [15:0] p2_s, p5_s;
  logic [63:0]        p1_w, p3_w, p6_w, p8_w, p9_w;
  logic [63:0]        p4_sh, p7_sh;

  assign t1_w  = $signed({16'h0, temp_cal[15:0]});
  assign t2_w  = $signed({{16{temp_cal[31]}}, temp_cal[31:16]});
  assign t3_w  = $signed({{16{temp_cal[47]}}, temp_cal[47:32]});
  assign h1_w  = $signed({24'h0, hum_cal[7:0]});
  assign h2_w  = $signed({{16{hum_cal[23]}}, hum_cal[23:8]});
  assign h3_w  = $signed({24'h0, hum_cal[31:24]});
  assign h4_w  = $signed({{20{hum_cal[43]}}, hum_cal[43:32]});
  assign h5_w  = $signed({{20{hum_cal[55]}}, hum_cal[55:44]});
  assign h6_w  = $signed({{24{hum_cal[63]}}, hum_cal[63:56]});
  assign p1_w  = {48'h0, press_cal_low[15:0]};
  assign p2_s  = $signed(press_cal_low[31:16]);
  assign p3_w  = {{48{press_cal_low[47]}}, press_cal_low[47:32]};
  assign p4_sh = {{13{press_cal_low[63]}}, press_cal_low[63:48], 35'h0};
  assign p5_s  = $signed(press_cal_high[15:0]);
  assign p6_w  = {{48{press_cal_high[31]}}, press_cal_high[31:16]};
  assign p7_sh = {{44{press_cal_high[47]}}, press_cal_high[47:32], 4'h0};
  assign p8_w  = {{48{press_cal_high[63]}}, press_cal_high[63:48]};
  assign p9_w  = {{48{press_cal_nine[15]}}, press_cal_nine};

  // Handshake and valid bits; the pipeline advances on every cycle.
  logic              accept;
  logic [OutStage:0] vld;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OutStage-1:0], accept};
    end
  end

  assign done = vld[OutStage];

  // Stage 0: capture the raw codes.
  logic [19:0] tadc0, padc0;
  logic [15:0] hadc0;

  always_ff @(posedge clk) begin
    if (accept) begin
      tadc0 <= temp_raw;
      padc0 <= press_raw;
      hadc0 <= hum_raw;
    end
  end

  logic [15:0] hadc_dl [HadcDly];
  logic [19:0] padc_dl [PadcDly];

  always_ff @(posedge clk) begin
    hadc_dl[0] <= hadc0;
    padc_dl[0] <= padc0;
    for (int i = 1; i < HadcDly; i++) hadc_dl[i] <= hadc_dl[i-1];
    for (int i = 1; i < PadcDly; i++) padc_dl[i] <= padc_dl[i-1];
  end

  // Temperature, stages 1 to 6; the fine value is ready at stage 4.
  logic signed [31:0] ta1, td1, tm2, tsq2, tv1_3, tm3_3, tfine4, tc5, tmc6;

  always_ff @(posedge clk) begin
    ta1    <= $signed({15'h0, tadc0[19:3]}) - (t1_w <<< 1);
    td1    <= $signed({16'h0, tadc0[19:4]}) - t1_w;
    tm2    <= ta1 * t2_w;
    tsq2   <= td1 * td1;
    tv1_3  <= tm2 >>> 11;
    tm3_3  <= (tsq2 >>> 12) * t3_w;
    tfine4 <= tv1_3 + (tm3_3 >>> 14);
    tc5    <= (tfine4 * 32'sd5 + 32'sd128) >>> 8;
    tmc6   <= tc5 * 32'sd10;
  end

  // Pressure, first half: divisor and dividend, stages 5 to 12.
  logic signed [63:0] pw1_5;
  logic signed [32:0] pw33;
  logic signed [65:0] psq_full;
  logic signed [48:0] pw5_full, pw2_full;
  logic [63:0]        psq6, pw5_6, pw2_6;
  logic [63:0]        pw5_dl [PwDly];
  logic [63:0]        pw2_dl [PwDly];
  logic [63:0]        m_a8, m_b8, pw2_9, pw1c_9, pe10, pn10, m_c12, m_d12;
  logic [20:0]        pbase;

  assign pw33     = pw1_5[32:0];
  assign psq_full = pw33 * pw33;
  assign pw5_full = pw33 * p5_s;
  assign pw2_full = pw33 * p2_s;
  assign pbase    = 21'd1048576 - {1'b0, padc_dl[PadcDly-1]};

  always_ff @(posedge clk) begin
    pw1_5 <= {{32{tfine4[31]}}, tfine4} - 64'sd128000;
    psq6  <= psq_full[63:0];
    pw5_6 <= {{15{pw5_full[48]}}, pw5_full};
    pw2_6 <= {{15{pw2_full[48]}}, pw2_full};
    pw5_dl[0] <= pw5_6;
    pw2_dl[0] <= pw2_6;
    for (int i = 1; i < PwDly; i++) begin
      pw5_dl[i] <= pw5_dl[i-1];
      pw2_dl[i] <= pw2_dl[i-1];
    end
    pw2_9  <= m_a8 + {pw5_dl[PwDly-1][46:0], 17'h0} + p4_sh;
    pw1c_9 <= 64'($signed(m_b8) >>> 8) + {pw2_dl[PwDly-1][51:0], 12'h0};
    pe10   <= 64'h0000_8000_0000_0000 + pw1c_9;
    pn10   <= {12'h0, pbase, 31'h0} - pw2_9;
  end

  thp_mul64 u_mul_a (.clk(clk), .a(psq6), .b(p6_w), .p(m_a8));
  thp_mul64 u_mul_b (.clk(clk), .a(psq6), .b(p3_w), .p(m_b8));
  thp_mul64 u_mul_c (.clk(clk), .a(pe10), .b(p1_w), .p(m_c12));
  thp_mul64 u_mul_d (.clk(clk), .a(pn10), .b(64'd3125), .p(m_d12));

  // Stage 13: signs and magnitudes for the divider; a zero divisor is flagged.
  logic [63:0] dsr12;
  logic [63:0] ma13, mb13, q77;
  logic        neg13, zero13;
  logic        neg_dl  [NegDly];
  logic        zero_dl [ZeroDly];

  assign dsr12 = 64'($signed(m_c12) >>> 33);

  always_ff @(posedge clk) begin
    ma13   <= m_d12[63] ? (64'h0 - m_d12) : m_d12;
    mb13   <= dsr12[63] ? (64'h0 - dsr12) : dsr12;
    neg13  <= m_d12[63] ^ dsr12[63];
    zero13 <= (dsr12 == 64'h0);
    neg_dl[0]  <= neg13;
    zero_dl[0] <= zero13;
    for (int i = 1; i < NegDly; i++)  neg_dl[i]  <= neg_dl[i-1];
    for (int i = 1; i < ZeroDly; i++) zero_dl[i] <= zero_dl[i-1];
  end

  thp_div u_div (.clk(clk), .dividend(ma13), .divisor(mb13), .quotient(q77));

  // Pressure, second half: stages 78 to 84.
  logic [63:0] pq78, qv78, m_e80, m_f80, m_g82, psum83, pfin84;
  logic [63:0] pq_dl [PqDly];
  logic [63:0] mf_dl [MfDly];

  assign qv78 = 64'($signed(pq78) >>> 13);

  always_ff @(posedge clk) begin
    pq78 <= neg_dl[NegDly-1] ? (64'h0 - q77) : q77;
    pq_dl[0] <= pq78;
    mf_dl[0] <= m_f80;
    for (int i = 1; i < PqDly; i++) pq_dl[i] <= pq_dl[i-1];
    for (int i = 1; i < MfDly; i++) mf_dl[i] <= mf_dl[i-1];
    psum83 <= pq_dl[PqDly-1] + 64'($signed(m_g82) >>> 25)
              + 64'($signed(mf_dl[MfDly-1]) >>> 19);
    pfin84 <= 64'($signed(psum83) >>> 8) + p7_sh;
  end

  thp_mul64 u_mul_e (.clk(clk), .a(qv78), .b(qv78), .p(m_e80));
  thp_mul64 u_mul_f (.clk(clk), .a(pq78), .b(p8_w), .p(m_f80));
  thp_mul64 u_mul_g (.clk(clk), .a(m_e80), .b(p9_w), .p(m_g82));

  // Humidity, stages 5 to 15.
  logic signed [31:0] hv5, hx5, hm5_6, hm6_6, hm3_6, hx6, hx7, ha7, hb7;
  logic signed [31:0] hy8, hx8, ht9, hx9, hz10, hx10, hvx11, hs11, hss12, hvx12;
  logic signed [31:0] hm13, hvx13, hv13;
  logic [28:0]        hc14;
  logic [26:0]        hprod14;
  logic [16:0]        hmrh15;

  assign hs11    = hvx11 >>> 15;
  assign hv13    = hvx13 - (hm13 >>> 4);
  assign hprod14 = {10'h0, hc14[28:12]} * 27'd1000;

  always_ff @(posedge clk) begin
    hv5   <= tfine4 - 32'sd76800;
    hx5   <= $signed({2'b00, hadc_dl[HadcDly-1], 14'h0}) - $signed({h4_w[11:0], 20'h0});
    hm5_6 <= h5_w * hv5;
    hm6_6 <= hv5 * h6_w;
    hm3_6 <= hv5 * h3_w;
    hx6   <= hx5;
    hx7   <= (hx6 - hm5_6 + 32'sd16384) >>> 15;
    ha7   <= hm6_6 >>> 10;
    hb7   <= (hm3_6 >>> 11) + 32'sd32768;
    hy8   <= ha7 * hb7;
    hx8   <= hx7;
    ht9   <= ((hy8 >>> 10) + 32'sd2097152) * h2_w;
    hx9   <= hx8;
    hz10  <= (ht9 + 32'sd8192) >>> 14;
    hx10  <= hx9;
    hvx11 <= hx10 * hz10;
    hss12 <= hs11 * hs11;
    hvx12 <= hvx11;
    hm13  <= (hss12 >>> 7) * h1_w;
    hvx13 <= hvx12;
    // Clamp the humidity value to the valid range before scaling.
    if (hv13[31]) begin
      hc14 <= '0;
    end else if (hv13 > 32'sd419430400) begin
      hc14 <= 29'd419430400;
    end else begin
      hc14 <= hv13[28:0];
    end
    hmrh15 <= has_humidity ? hprod14[26:10] : 17'h0;
  end

  // Alignment of temperature and humidity with the pressure result.
  logic signed [31:0] tmc_dl [TmcDly];
  logic [16:0]        hum_dl [HumDly];

  always_ff @(posedge clk) begin
    tmc_dl[0] <= tmc6;
    hum_dl[0] <= hmrh15;
    for (int i = 1; i < TmcDly; i++) tmc_dl[i] <= tmc_dl[i-1];
    for (int i = 1; i < HumDly; i++) hum_dl[i] <= hum_dl[i-1];
  end

  // Output registers; the low 32 bits of the pressure value are divided by 256.
  always_ff @(posedge clk) begin
    temperature_mc <= tmc_dl[TmcDly-1];
    pressure_pa    <= zero_dl[ZeroDly-1] ? 24'h0 : pfin84[31:8];
    humidity_mrh   <= hum_dl[HumDly-1];
  end

endmodule

`default_nettype wire

// File: rtl/thp_checker.sv
// Port-level checks for the compensation block and the bind that attaches them.
`default_nettype none

module thp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [16:0] humidity_mrh
);
  import thp_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Latency done)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result strobe without a matching transaction");

  a_never_busy: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("block refused a transaction out of reset");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (humidity_mrh <= HumMaxMrh))
    else $error("humidity result above full scale");

endmodule

bind thp_sensor_compensation thp_checker u_thp_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .humidity_mrh(humidity_mrh)
);

`default_nettype wire
